// ===== src/quadratic_root_solver_macros.svh =====
// assertion macros for the quadratic root solver
// no dependencies; included by modules that carry assertions
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// same-cycle implication, disabled during reset
`define QRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define QRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/qrs_pkg.sv =====
// shared types and constants of the quadratic root solver
// no dependencies
package qrs_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_COEF_EPSILON   = 2'd0;
    localparam logic [1:0] CFG_IMAG_TOLERANCE = 2'd1;

    localparam int EPS_W      = 31;
    localparam int TOL_W      = 17;
    localparam int DEN_W      = 66;
    localparam int NUM_BASE_W = 69;
    localparam int ISQ_W      = 128;

    // class of a request as decided by the front end
    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_LINEAR,
        CLS_QUAD
    } t_cls;

    // request as it travels through the queue
    typedef struct packed {
        t_cls               cls;
        logic signed [31:0] a2r;
        logic signed [31:0] a2i;
        logic signed [31:0] a1r;
        logic signed [31:0] a1i;
        logic signed [31:0] a0r;
        logic signed [31:0] a0i;
    } t_item;

    // back end sequencer states
    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_DISC,
        B_SQ,
        B_MSTART,
        B_MWAIT,
        B_PSTART,
        B_PWAIT,
        B_QSTART,
        B_QWAIT,
        B_NUM,
        B_NMUL,
        B_NADD,
        B_DSTART,
        B_DWAIT,
        B_DONE
    } t_bstate;

endpackage

// ===== src/qrs_fifo.sv =====
// short request queue between front and back end
// depends on nothing but its parameters
module qrs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ===== src/qrs_front.sv =====
// front end: takes requests, squares the leading coefficients and classifies
// depends on qrs_pkg
module qrs_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [31:0]          i_coef2_re,
    input  logic signed [31:0]          i_coef2_im,
    input  logic signed [31:0]          i_coef1_re,
    input  logic signed [31:0]          i_coef1_im,
    input  logic signed [31:0]          i_coef0_re,
    input  logic signed [31:0]          i_coef0_im,
    input  logic [qrs_pkg::EPS_W-1:0]   i_coef_epsilon,
    input  logic                        i_full,
    output logic                        o_push,
    output qrs_pkg::t_item              o_item
);
    logic            r_s1_v, r_s2_v;
    qrs_pkg::t_item  r_s1_item, r_s2_item;
    logic [63:0]     r_m2, r_m1;
    logic [61:0]     r_eps2;
    logic signed [63:0] w_sq2r, w_sq2i, w_sq1r, w_sq1i;
    logic            w_load2, w_below2, w_below1;

    assign w_load2    = !r_s2_v || !i_full;
    assign o_in_stall = r_s1_v && !w_load2;
    assign o_push     = r_s2_v && !i_full;

    // squared magnitudes of the two leading coefficients
    assign w_sq2r = r_s1_item.a2r * r_s1_item.a2r;
    assign w_sq2i = r_s1_item.a2i * r_s1_item.a2i;
    assign w_sq1r = r_s1_item.a1r * r_s1_item.a1r;
    assign w_sq1i = r_s1_item.a1i * r_s1_item.a1i;

    // below-epsilon tests; an exact zero always counts as below
    assign w_below2 = (r_m2 == '0) || (r_m2 < {2'b00, r_eps2});
    assign w_below1 = (r_m1 == '0) || (r_m1 < {2'b00, r_eps2});

    always_comb begin
        o_item = r_s2_item;
        if (!w_below2) begin
            o_item.cls = qrs_pkg::CLS_QUAD;
        end else if (!w_below1) begin
            o_item.cls = qrs_pkg::CLS_LINEAR;
        end else begin
            o_item.cls = qrs_pkg::CLS_NONE;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (w_load2) begin
                r_s2_v <= r_s1_v;
            end
            if (!r_s1_v || w_load2) begin
                r_s1_v <= i_in_valid;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (!r_s1_v || w_load2) begin
            r_s1_item.cls <= qrs_pkg::CLS_NONE;
            r_s1_item.a2r <= i_coef2_re;
            r_s1_item.a2i <= i_coef2_im;
            r_s1_item.a1r <= i_coef1_re;
            r_s1_item.a1i <= i_coef1_im;
            r_s1_item.a0r <= i_coef0_re;
            r_s1_item.a0i <= i_coef0_im;
        end
        if (w_load2) begin
            r_s2_item <= r_s1_item;
            r_m2      <= w_sq2r + w_sq2i;
            r_m1      <= w_sq1r + w_sq1i;
            r_eps2    <= i_coef_epsilon * i_coef_epsilon;
        end
    end
endmodule

// ===== src/qrs_isqrt.sv =====
// iterative floor square root, two radicand bits per cycle
// depends on nothing but its parameter
module qrs_isqrt #(
    parameter int IW = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IW-1:0]     i_n,
    output logic              o_busy,
    output logic [IW/2-1:0]   o_root
);
    localparam int RW = IW / 2 + 2;
    localparam int CW = $clog2(IW / 2 + 1);

    logic [IW-1:0]   r_n;
    logic [RW-1:0]   r_rem;
    logic [IW/2-1:0] r_root;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic [RW-1:0]   w_t, w_trial;
    logic            w_ge;

    assign w_t     = {r_rem[RW-3:0], r_n[IW-1:IW-2]};
    assign w_trial = {r_root, 2'b01};
    assign w_ge    = (w_t >= w_trial);
    assign o_busy  = r_busy;
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(IW / 2);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // one root digit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n    <= {r_n[IW-3:0], 2'b00};
            r_rem  <= w_ge ? (w_t - w_trial) : w_t;
            r_root <= {r_root[IW/2-2:0], w_ge};
        end
    end
endmodule

// ===== src/qrs_div.sv =====
// restoring divider, one quotient bit per cycle, saturating signed result
// depends on nothing but its parameters
module qrs_div #(
    parameter int NW = 85,
    parameter int DW = 66
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NW-1:0]       i_num,
    input  logic                i_neg,
    input  logic [DW-1:0]       i_den,
    output logic                o_busy,
    output logic signed [31:0]  o_quot,
    output logic                o_sat
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem, r_den;
    logic [32:0]   r_q;
    logic          r_ovf, r_neg, r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   w_t, w_diff;
    logic          w_ge, w_big;

    assign w_t    = {r_rem, r_num[NW-1]};
    assign w_diff = w_t - {1'b0, r_den};
    assign w_ge   = (w_t >= {1'b0, r_den});
    assign o_busy = r_busy;

    // saturation of the magnitude quotient
    always_comb begin
        if (r_neg) begin
            w_big  = r_ovf || r_q[32] || (r_q[31] && (r_q[30:0] != '0));
            o_quot = w_big ? 32'sh8000_0000 : -$signed(r_q[31:0]);
        end else begin
            w_big  = r_ovf || r_q[32] || r_q[31];
            o_quot = w_big ? 32'sh7FFF_FFFF : $signed(r_q[31:0]);
        end
        o_sat = w_big;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_neg <= i_neg;
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
            r_q   <= {r_q[31:0], w_ge};
            r_ovf <= r_ovf | r_q[32];
        end
    end
endmodule

// ===== src/qrs_back.sv =====
// back end: discriminant, square roots and complex divisions, output register
// depends on qrs_pkg, qrs_isqrt, qrs_div and the assertion macros
`include "quadratic_root_solver_macros.svh"

module qrs_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [qrs_pkg::TOL_W-1:0]   i_imag_tolerance,
    input  logic                        i_empty,
    input  qrs_pkg::t_item              i_head,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_root_count,
    output logic signed [31:0]          o_first_re,
    output logic signed [31:0]          o_first_im,
    output logic signed [31:0]          o_second_re,
    output logic signed [31:0]          o_second_im,
    output logic                        o_saturated
);
    localparam int NW = qrs_pkg::NUM_BASE_W + FRAC_BITS;
    localparam int DW = qrs_pkg::DEN_W;
    localparam int IW = qrs_pkg::ISQ_W;

    qrs_pkg::t_bstate r_state, n_state;
    qrs_pkg::t_item   r_item;
    logic signed [63:0] r_p11r, r_p11i, r_p20r, r_p20i, r_p1x, r_p2x1, r_p2x2;
    logic signed [63:0] r_p22r, r_p22i;
    logic               r_xneg, r_yneg, r_second, r_sat;
    logic [63:0]        r_ax, r_ay, r_p, r_q;
    logic [DW-1:0]      r_den;
    logic [1:0]         r_k;
    logic [127:0]       r_acc;
    logic [33:0]        r_dr;
    logic signed [35:0] r_di, r_nr, r_ni;
    logic signed [31:0] r_dvr, r_dvi;
    logic signed [67:0] r_pa, r_pb, r_pc, r_pd;
    logic [68:0]        r_nre_mag, r_nim_mag;
    logic               r_nre_neg, r_nim_neg;
    logic signed [31:0] r_r1r, r_r1i, r_r2r, r_r2i;
    logic               r_out_valid, r_out_sat;
    logic [1:0]         r_out_count;
    logic signed [31:0] r_out_fr, r_out_fi, r_out_sr, r_out_si;

    logic               w_out_free, w_lin;
    logic               w_isq_start, w_isq_busy;
    logic [IW-1:0]      w_isq_n;
    logic [IW/2-1:0]    w_isq_root;
    logic               w_div_start, w_dre_busy, w_dim_busy, w_dre_sat, w_dim_sat;
    logic signed [31:0] w_dre_q, w_dim_q;
    logic signed [67:0] w_x, w_y;
    logic [63:0]        w_xs, w_ys;
    logic [31:0]        w_ma, w_mb, w_na, w_nb;
    logic [63:0]        w_pa, w_pb;
    logic [64:0]        w_psum;
    logic signed [68:0] w_nre, w_nim;
    logic signed [35:0] w_a1r, w_a1i, w_sdr;
    logic [32:0]        w_m1i, w_m2i;
    logic               w_real1, w_real2;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_lin       = (r_item.cls == qrs_pkg::CLS_LINEAR);
    assign o_out_valid = r_out_valid;
    assign o_root_count = r_out_count;
    assign o_first_re  = r_out_fr;
    assign o_first_im  = r_out_fi;
    assign o_second_re = r_out_sr;
    assign o_second_im = r_out_si;
    assign o_saturated = r_out_sat;

    // shared units
    qrs_isqrt #(.IW(IW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_isq_start),
        .i_n     (w_isq_n),
        .o_busy  (w_isq_busy),
        .o_root  (w_isq_root)
    );

    qrs_div #(.NW(NW), .DW(DW)) u_div_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_nre_mag, {FRAC_BITS{1'b0}}}),
        .i_neg   (r_nre_neg),
        .i_den   (r_den),
        .o_busy  (w_dre_busy),
        .o_quot  (w_dre_q),
        .o_sat   (w_dre_sat)
    );

    qrs_div #(.NW(NW), .DW(DW)) u_div_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_nim_mag, {FRAC_BITS{1'b0}}}),
        .i_neg   (r_nim_neg),
        .i_den   (r_den),
        .o_busy  (w_dim_busy),
        .o_quot  (w_dim_q),
        .o_sat   (w_dim_sat)
    );

    // discriminant, scaled down by sixteen
    assign w_x = {{4{r_p11r[63]}}, r_p11r} - {{4{r_p11i[63]}}, r_p11i}
               - (({{4{r_p20r[63]}}, r_p20r} - {{4{r_p20i[63]}}, r_p20i}) <<< 2);
    assign w_y = ({{4{r_p1x[63]}}, r_p1x} <<< 1)
               - (({{4{r_p2x1[63]}}, r_p2x1} + {{4{r_p2x2[63]}}, r_p2x2}) <<< 2);
    assign w_xs = w_x[67:4];
    assign w_ys = w_y[67:4];

    // 64x64 squares split into 32x32 partial products
    always_comb begin
        case (r_k)
            2'd0: begin
                w_ma = r_ax[31:0];  w_mb = r_ax[31:0];
                w_na = r_ay[31:0];  w_nb = r_ay[31:0];
            end
            2'd1: begin
                w_ma = r_ax[63:32]; w_mb = r_ax[31:0];
                w_na = r_ay[63:32]; w_nb = r_ay[31:0];
            end
            default: begin
                w_ma = r_ax[63:32]; w_mb = r_ax[63:32];
                w_na = r_ay[63:32]; w_nb = r_ay[63:32];
            end
        endcase
    end
    assign w_pa   = w_ma * w_mb;
    assign w_pb   = w_na * w_nb;
    assign w_psum = {1'b0, w_pa} + {1'b0, w_pb};

    // numerator terms of the next root
    assign w_a1r = {{4{r_item.a1r[31]}}, r_item.a1r};
    assign w_a1i = {{4{r_item.a1i[31]}}, r_item.a1i};
    assign w_sdr = $signed({2'b00, r_dr});
    assign w_nre = {r_pa[67], r_pa} + {r_pb[67], r_pb};
    assign w_nim = {r_pc[67], r_pc} - {r_pd[67], r_pd};

    // root ordering and tolerance
    assign w_m1i   = r_r1i[31] ? (33'd0 - {r_r1i[31], r_r1i}) : {1'b0, r_r1i};
    assign w_m2i   = r_r2i[31] ? (33'd0 - {r_r2i[31], r_r2i}) : {1'b0, r_r2i};
    assign w_real1 = (w_m1i < {16'd0, i_imag_tolerance});
    assign w_real2 = (w_m2i < {16'd0, i_imag_tolerance});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qrs_pkg::B_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_head.cls == qrs_pkg::CLS_NONE) ?
                              qrs_pkg::B_DONE : qrs_pkg::B_MUL;
                end
            end
            qrs_pkg::B_MUL:    n_state = qrs_pkg::B_DISC;
            qrs_pkg::B_DISC:   n_state = w_lin ? qrs_pkg::B_NUM : qrs_pkg::B_SQ;
            qrs_pkg::B_SQ:     n_state = (r_k == 2'd2) ? qrs_pkg::B_MSTART : qrs_pkg::B_SQ;
            qrs_pkg::B_MSTART: n_state = qrs_pkg::B_MWAIT;
            qrs_pkg::B_MWAIT:  n_state = w_isq_busy ? qrs_pkg::B_MWAIT : qrs_pkg::B_PSTART;
            qrs_pkg::B_PSTART: n_state = qrs_pkg::B_PWAIT;
            qrs_pkg::B_PWAIT:  n_state = w_isq_busy ? qrs_pkg::B_PWAIT : qrs_pkg::B_QSTART;
            qrs_pkg::B_QSTART: n_state = qrs_pkg::B_QWAIT;
            qrs_pkg::B_QWAIT:  n_state = w_isq_busy ? qrs_pkg::B_QWAIT : qrs_pkg::B_NUM;
            qrs_pkg::B_NUM:    n_state = qrs_pkg::B_NMUL;
            qrs_pkg::B_NMUL:   n_state = qrs_pkg::B_NADD;
            qrs_pkg::B_NADD:   n_state = qrs_pkg::B_DSTART;
            qrs_pkg::B_DSTART: n_state = qrs_pkg::B_DWAIT;
            qrs_pkg::B_DWAIT: begin
                if (!w_dre_busy && !w_dim_busy) begin
                    n_state = (w_lin || r_second) ? qrs_pkg::B_DONE : qrs_pkg::B_NUM;
                end
            end
            qrs_pkg::B_DONE:   n_state = w_out_free ? qrs_pkg::B_IDLE : qrs_pkg::B_DONE;
            default:           n_state = qrs_pkg::B_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_pop       = 1'b0;
        w_isq_start = 1'b0;
        w_div_start = 1'b0;
        w_isq_n     = r_acc;
        unique case (r_state)
            qrs_pkg::B_IDLE:   o_pop = !i_empty;
            qrs_pkg::B_MSTART: w_isq_start = 1'b1;
            qrs_pkg::B_PSTART: begin
                w_isq_start = 1'b1;
                w_isq_n     = {61'd0, r_p, 3'b000};
            end
            qrs_pkg::B_QSTART: begin
                w_isq_start = 1'b1;
                w_isq_n     = {61'd0, r_q, 3'b000};
            end
            qrs_pkg::B_DSTART: w_div_start = 1'b1;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // state register and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qrs_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == qrs_pkg::B_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            qrs_pkg::B_IDLE: begin
                r_item <= i_head;
                r_sat  <= 1'b0;
            end
            qrs_pkg::B_MUL: begin
                r_p11r <= r_item.a1r * r_item.a1r;
                r_p11i <= r_item.a1i * r_item.a1i;
                r_p20r <= r_item.a2r * r_item.a0r;
                r_p20i <= r_item.a2i * r_item.a0i;
                r_p1x  <= r_item.a1r * r_item.a1i;
                r_p2x1 <= r_item.a2r * r_item.a0i;
                r_p2x2 <= r_item.a2i * r_item.a0r;
                r_p22r <= r_item.a2r * r_item.a2r;
                r_p22i <= r_item.a2i * r_item.a2i;
            end
            qrs_pkg::B_DISC: begin
                r_xneg   <= w_xs[63];
                r_yneg   <= w_ys[63];
                r_ax     <= w_xs[63] ? (64'd0 - w_xs) : w_xs;
                r_ay     <= w_ys[63] ? (64'd0 - w_ys) : w_ys;
                r_k      <= 2'd0;
                r_second <= 1'b0;
                if (w_lin) begin
                    r_den <= {2'b00, r_p11r} + {2'b00, r_p11i};
                    r_dvr <= r_item.a1r;
                    r_dvi <= r_item.a1i;
                end else begin
                    r_den <= ({2'b00, r_p22r} + {2'b00, r_p22i}) << 1;
                    r_dvr <= r_item.a2r;
                    r_dvi <= r_item.a2i;
                end
            end
            qrs_pkg::B_SQ: begin
                r_k <= r_k + 1'b1;
                case (r_k)
                    2'd0:    r_acc <= {63'd0, w_psum};
                    2'd1:    r_acc <= r_acc + {30'd0, w_psum, 33'd0};
                    default: r_acc <= r_acc + {w_psum[63:0], 64'd0};
                endcase
            end
            qrs_pkg::B_MWAIT: begin
                if (!w_isq_busy) begin
                    r_p <= r_xneg ? (w_isq_root - r_ax) : (w_isq_root + r_ax);
                    r_q <= r_xneg ? (w_isq_root + r_ax) : (w_isq_root - r_ax);
                end
            end
            qrs_pkg::B_PWAIT: begin
                r_dr <= w_isq_root[33:0];
            end
            qrs_pkg::B_QWAIT: begin
                r_di <= r_yneg ? -$signed({2'b00, w_isq_root[33:0]})
                               :  $signed({2'b00, w_isq_root[33:0]});
            end
            qrs_pkg::B_NUM: begin
                if (w_lin) begin
                    r_nr <= -$signed({{4{r_item.a0r[31]}}, r_item.a0r});
                    r_ni <= -$signed({{4{r_item.a0i[31]}}, r_item.a0i});
                end else if (r_second) begin
                    r_nr <= -w_a1r + w_sdr;
                    r_ni <= -w_a1i + r_di;
                end else begin
                    r_nr <= -w_a1r - w_sdr;
                    r_ni <= -w_a1i - r_di;
                end
            end
            qrs_pkg::B_NMUL: begin
                r_pa <= r_nr * r_dvr;
                r_pb <= r_ni * r_dvi;
                r_pc <= r_ni * r_dvr;
                r_pd <= r_nr * r_dvi;
            end
            qrs_pkg::B_NADD: begin
                r_nre_neg <= w_nre[68];
                r_nim_neg <= w_nim[68];
                r_nre_mag <= w_nre[68] ? (69'd0 - w_nre) : w_nre;
                r_nim_mag <= w_nim[68] ? (69'd0 - w_nim) : w_nim;
            end
            qrs_pkg::B_DWAIT: begin
                if (!w_dre_busy && !w_dim_busy) begin
                    r_sat    <= r_sat | w_dre_sat | w_dim_sat;
                    r_second <= 1'b1;
                    if (r_second) begin
                        r_r2r <= w_dre_q;
                        r_r2i <= w_dim_q;
                    end else begin
                        r_r1r <= w_dre_q;
                        r_r1i <= w_dim_q;
                    end
                end
            end
            qrs_pkg::B_DONE: begin
                if (w_out_free) begin
                    r_out_sat <= r_sat;
                    case (r_item.cls)
                        qrs_pkg::CLS_LINEAR: begin
                            r_out_count <= 2'd1;
                            r_out_fr    <= r_r1r;
                            r_out_fi    <= r_r1i;
                            r_out_sr    <= r_r1r;
                            r_out_si    <= r_r1i;
                        end
                        qrs_pkg::CLS_QUAD: begin
                            r_out_count <= 2'd2;
                            if (w_real1) begin
                                r_out_fr <= r_r1r;
                                r_out_fi <= '0;
                                r_out_sr <= r_r2r;
                                r_out_si <= w_real2 ? '0 : r_r2i;
                            end else begin
                                r_out_fr <= r_r2r;
                                r_out_fi <= w_real2 ? '0 : r_r2i;
                                r_out_sr <= r_r1r;
                                r_out_si <= r_r1i;
                            end
                        end
                        default: begin
                            r_out_count <= 2'd0;
                            r_out_fr    <= '0;
                            r_out_fi    <= '0;
                            r_out_sr    <= '0;
                            r_out_si    <= '0;
                            r_out_sat   <= 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // checks
    `QRS_ASSERT_IMP(a_none_zero, i_clk, i_rst_n,
        o_out_valid && o_root_count == 2'd0,
        o_first_re == 0 && o_first_im == 0 && o_second_re == 0 && o_second_im == 0
        && !o_saturated,
        "no-root result carries nonzero fields")
    `QRS_ASSERT_IMP(a_single_dup, i_clk, i_rst_n,
        o_out_valid && o_root_count == 2'd1,
        o_first_re == o_second_re && o_first_im == o_second_im,
        "single root differs between slots")
    `QRS_ASSERT_IMP(a_div_lockstep, i_clk, i_rst_n,
        r_state == qrs_pkg::B_DWAIT,
        w_dre_busy == w_dim_busy,
        "real and imaginary dividers out of step")
endmodule

// ===== src/quadratic_root_solver.sv =====
// top level of the complex quadratic root solver
// depends on qrs_pkg, qrs_front, qrs_fifo and qrs_back
//
// Solves a2*t^2 + a1*t + a0 = 0 for complex coefficients in signed fixed point
// with FRAC_BITS fraction bits. The front end accepts one request per cycle
// unless it stalls, squares the leading coefficients and classifies each request
// (no root, single root, or quadratic) into a four-entry queue. The back end works
// on one request at a time: a quadratic runs the shared 64-step square root unit
// three times, and every request with a root runs the bit-serial divider pair once
// per root, 69 + FRAC_BITS steps each. The finished result sits in an output
// register while the back end already starts on the next request.
module quadratic_root_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [31:0]  i_coef2_re,
    input  logic signed [31:0]  i_coef2_im,
    input  logic signed [31:0]  i_coef1_re,
    input  logic signed [31:0]  i_coef1_im,
    input  logic signed [31:0]  i_coef0_re,
    input  logic signed [31:0]  i_coef0_im,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_root_count,
    output logic signed [31:0]  o_first_re,
    output logic signed [31:0]  o_first_im,
    output logic signed [31:0]  o_second_re,
    output logic signed [31:0]  o_second_im,
    output logic                o_saturated,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [30:0]         i_cfg_data
);
    logic [qrs_pkg::EPS_W-1:0] r_coef_epsilon;
    logic [qrs_pkg::TOL_W-1:0] r_imag_tolerance;
    logic                      w_push, w_pop, w_full, w_empty;
    qrs_pkg::t_item            w_push_item, w_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_epsilon   <= qrs_pkg::EPS_W'(1);
            r_imag_tolerance <= qrs_pkg::TOL_W'(66);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                qrs_pkg::CFG_COEF_EPSILON:   r_coef_epsilon   <= i_cfg_data;
                qrs_pkg::CFG_IMAG_TOLERANCE: r_imag_tolerance <= i_cfg_data[16:0];
                default: begin
                    r_coef_epsilon <= r_coef_epsilon;
                end
            endcase
        end
    end

    qrs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_coef2_re     (i_coef2_re),
        .i_coef2_im     (i_coef2_im),
        .i_coef1_re     (i_coef1_re),
        .i_coef1_im     (i_coef1_im),
        .i_coef0_re     (i_coef0_re),
        .i_coef0_im     (i_coef0_im),
        .i_coef_epsilon (r_coef_epsilon),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    qrs_fifo #(.W($bits(qrs_pkg::t_item)), .DEPTH(4)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    qrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_imag_tolerance (r_imag_tolerance),
        .i_empty          (w_empty),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_root_count     (o_root_count),
        .o_first_re       (o_first_re),
        .o_first_im       (o_first_im),
        .o_second_re      (o_second_re),
        .o_second_im      (o_second_im),
        .o_saturated      (o_saturated)
    );
endmodule

// ===== tb/quadratic_root_solver_test.sv =====
// self-checking testbench for the complex quadratic root solver
// depends on qrs_pkg and quadratic_root_solver; holds its own exact root predictor
`timescale 1ns / 1ps

module quadratic_root_solver_test;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES = 2 * 16 + 400;
    localparam int RANDOM_ITEMS = 1600;

    typedef struct {
        logic [1:0]         count;
        logic signed [31:0] first_re;
        logic signed [31:0] first_im;
        logic signed [31:0] second_re;
        logic signed [31:0] second_im;
        logic               saturated;
    } t_roots;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [31:0] i_coef2_re, i_coef2_im, i_coef1_re, i_coef1_im;
    logic signed [31:0] i_coef0_re, i_coef0_im;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_root_count;
    logic signed [31:0] o_first_re, o_first_im, o_second_re, o_second_im;
    logic               o_saturated;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [30:0]        i_cfg_data;

    // predictor copy of the registers
    logic [30:0] eps_reg;
    logic [16:0] tol_reg;

    t_roots roots_q[$];
    int     cycle_cnt;
    int     mismatch_cnt;
    int     burst_left;

    quadratic_root_solver u_dut (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // floor integer square root
    function automatic logic [63:0] int_sqrt(input logic [127:0] n);
        logic [63:0]  r;
        logic [127:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = {64'd0, r | (64'd1 << b)};
            if (n >= c * c) r = c[63:0];
        end
        return r;
    endfunction

    // (n << 16) / den, truncated toward zero and clipped to 32 bits
    function automatic logic signed [31:0] clip_div(input logic signed [127:0] n,
                                                    input logic [127:0] den,
                                                    inout logic sat);
        logic         neg;
        logic [127:0] q;
        neg = n < 0;
        q = ((neg ? -n : n) << 16) / den;
        if (neg) begin
            if (q > 128'h8000_0000) begin
                sat = 1'b1;
                return 32'sh8000_0000;
            end
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    // complex n / (d << dsh)
    function automatic void cplx_div(input logic signed [127:0] nr, ni, dr, di,
                                     input int dsh,
                                     output logic signed [31:0] qr, qi,
                                     inout logic sat);
        logic signed [127:0] num_re, num_im;
        logic [127:0]        den;
        num_re = nr * dr + ni * di;
        num_im = ni * dr - nr * di;
        den = (dr * dr + di * di) << dsh;
        if (den == 0) begin
            qr = '0;
            qi = '0;
        end else begin
            qr = clip_div(num_re, den, sat);
            qi = clip_div(num_im, den, sat);
        end
    endfunction

    function automatic logic below_eps(input logic signed [127:0] re, im);
        logic [127:0] m2, e;
        m2 = re * re + im * im;
        e = {97'd0, eps_reg};
        return m2 == 0 || m2 < e * e;
    endfunction

    // expected roots of one coefficient set
    function automatic t_roots solve_roots(input logic signed [31:0] c2r, c2i, c1r, c1i,
                                           input logic signed [31:0] c0r, c0i);
        t_roots              res;
        logic signed [127:0] a2r, a2i, a1r, a1i, a0r, a0i, x, y, sr, si;
        logic [127:0]        ax, ay;
        logic [63:0]         m, p, q;
        logic signed [31:0]  r1r, r1i, r2r, r2i;
        logic                sat, real1, real2;
        a2r = c2r; a2i = c2i; a1r = c1r; a1i = c1i; a0r = c0r; a0i = c0i;
        sat = 1'b0;
        res = '{2'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0};
        if (below_eps(a2r, a2i)) begin
            if (!below_eps(a1r, a1i)) begin
                cplx_div(-a0r, -a0i, a1r, a1i, 0, r1r, r1i, sat);
                res = '{2'd1, r1r, r1i, r1r, r1i, sat};
            end
        end else begin
            // discriminant, then its principal square root
            x = (a1r * a1r - a1i * a1i - ((a2r * a0r - a2i * a0i) <<< 2)) >>> 4;
            y = (((a1r * a1i) <<< 1) - ((a2r * a0i + a2i * a0r) <<< 2)) >>> 4;
            ax = {64'd0, x < 0 ? 64'(-x) : 64'(x)};
            ay = {64'd0, y < 0 ? 64'(-y) : 64'(y)};
            m = int_sqrt(ax * ax + ay * ay);
            p = x < 0 ? m - ax[63:0] : m + ax[63:0];
            q = x < 0 ? m + ax[63:0] : m - ax[63:0];
            sr = {64'd0, int_sqrt({64'd0, p} << 3)};
            si = {64'd0, int_sqrt({64'd0, q} << 3)};
            if (y < 0) si = -si;
            cplx_div(-a1r - sr, -a1i - si, a2r, a2i, 1, r1r, r1i, sat);
            cplx_div(-a1r + sr, -a1i + si, a2r, a2i, 1, r2r, r2i, sat);
            real1 = (r1i < 0 ? -64'(r1i) : 64'(r1i)) < 64'(tol_reg);
            real2 = (r2i < 0 ? -64'(r2i) : 64'(r2i)) < 64'(tol_reg);
            if (real2) r2i = '0;
            if (real1) res = '{2'd2, r1r, 32'sd0, r2r, r2i, sat};
            else       res = '{2'd2, r2r, r2i, r1r, r1i, sat};
        end
        return res;
    endfunction

    // random coefficient part with a spread of magnitudes
    function automatic logic signed [31:0] rand_part();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return $signed(32'($urandom_range(0, 6))) - 3;
            default: return $signed($urandom) >>> $urandom_range(0, 31);
        endcase
    endfunction

    // send one request, bursts with random gaps between them
    task automatic send_request(input logic signed [31:0] c2r, c2i, c1r, c1i, c0r, c0i);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_coef2_re <= c2r; i_coef2_im <= c2i;
        i_coef1_re <= c1r; i_coef1_im <= c1i;
        i_coef0_re <= c0r; i_coef0_im <= c0i;
        do @(posedge i_clk); while (o_in_stall);
        roots_q.push_back(solve_roots(c2r, c2i, c1r, c1i, c0r, c0i));
    endtask

    // stop sending and wait for every outstanding request to finish
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (roots_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write, then the write enable is dropped again
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == qrs_pkg::CFG_COEF_EPSILON) eps_reg = data;
        else if (idx == qrs_pkg::CFG_IMAG_TOLERANCE) tol_reg = data[16:0];
        @(posedge i_clk);
    endtask

    // hand-picked cases at reset settings
    task automatic test_directed();
        localparam logic signed [31:0] ONE = 32'sh0001_0000;
        send_request(0, 0, 0, 0, 0, 0);                         // no root
        send_request(0, 0, 0, 0, ONE, ONE);                     // no root, nonzero a0
        send_request(0, 0, ONE, 0, -2 * ONE, 0);                // single root
        send_request(0, 0, 1, 0, 32'sh7FFF_FFFF, 0);            // single root, clipped
        send_request(1, 0, 32'sh7FFF_FFFF, 0, 0, 0);            // tiny leading term
        send_request(ONE, 0, -3 * ONE, 0, 2 * ONE, 0);          // two real roots
        send_request(ONE, 0, -2 * ONE, 0, ONE, 0);              // double root
        send_request(ONE, 0, 0, 0, ONE, 0);                     // discriminant on negative axis
        send_request(ONE, 0, 0, 0, 0, ONE);                     // discriminant with negative imag
        send_request(ONE, ONE, ONE, -ONE, ONE, 0);              // complex roots
        send_request(ONE, 0, 0, 0, -ONE, 40);                   // roots near the real axis
        send_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_request(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(1, 0, 0, 0, 32'sh7FFF_FFFF, 0);            // huge roots
        drain();
    endtask

    // random requests, mostly quadratics, some degenerate
    task automatic test_random(input int n_items);
        logic signed [31:0] c[6];
        for (int k = 0; k < n_items; k++) begin
            foreach (c[j]) c[j] = rand_part();
            case ($urandom_range(0, 9))
                0: begin c[0] = 0; c[1] = 0; c[2] = 0; c[3] = 0; end
                1: begin c[0] = 0; c[1] = $urandom_range(0, 1); end
                2: begin c[0] = 0; c[1] = 0; end
                default: ;
            endcase
            send_request(c[0], c[1], c[2], c[3], c[4], c[5]);
        end
        drain();
    endtask

    // register settings, extremes included
    task automatic test_settings();
        write_reg(qrs_pkg::CFG_COEF_EPSILON, 31'd0);
        write_reg(qrs_pkg::CFG_IMAG_TOLERANCE, 31'd0);
        test_random(RANDOM_ITEMS / 5);
        write_reg(qrs_pkg::CFG_COEF_EPSILON, 31'h7FFF_FFFF);
        write_reg(qrs_pkg::CFG_IMAG_TOLERANCE, 31'd65536);
        test_random(RANDOM_ITEMS / 5);
        write_reg(qrs_pkg::CFG_COEF_EPSILON, 31'd4096);
        write_reg(qrs_pkg::CFG_IMAG_TOLERANCE, 31'h7FFF_FFFF);
        write_reg(2'd2, 31'd12345);
        write_reg(2'd3, 31'd0);
        test_random(RANDOM_ITEMS / 5);
        write_reg(qrs_pkg::CFG_COEF_EPSILON, 31'($urandom));
        write_reg(qrs_pkg::CFG_IMAG_TOLERANCE, 31'($urandom_range(0, 2000)));
        test_random(RANDOM_ITEMS / 5);
    endtask

    // main sequence
    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_coef2_re <= '0; i_coef2_im <= '0;
        i_coef1_re <= '0; i_coef1_im <= '0;
        i_coef0_re <= '0; i_coef0_im <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        eps_reg = 31'd1;
        tol_reg = 17'd66;
        mismatch_cnt = 0;
        burst_left = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(RANDOM_ITEMS / 5);
        test_settings();
        if (mismatch_cnt == 0)
            $display("[quadratic_root_solver] OK");
        else
            $display("[quadratic_root_solver] ERROR");
        $finish;
    end

    // receiver stall pattern, its character chosen by cycle counter bits 12 and 11
    always @(posedge i_clk) begin
        case (cycle_cnt[12:11])
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2'd2: i_out_stall <= (cycle_cnt[8:0] < 9'd120);
            default: i_out_stall <= 1'($urandom_range(0, 1));
        endcase
    end

    // cycle counter and timeout
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("[quadratic_root_solver] ERROR");
            $finish;
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_roots want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (roots_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result at cycle %0d", cycle_cnt);
            end else begin
                want = roots_q.pop_front();
                if (o_root_count !== want.count || o_first_re !== want.first_re
                    || o_first_im !== want.first_im || o_second_re !== want.second_re
                    || o_second_im !== want.second_im || o_saturated !== want.saturated) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                                 want.count, want.first_re, want.first_im, want.second_re,
                                 want.second_im, want.saturated, o_root_count, o_first_re,
                                 o_first_im, o_second_re, o_second_im, o_saturated);
                end
            end
        end
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/qrs_pkg.sv
src/qrs_fifo.sv
src/qrs_front.sv
src/qrs_isqrt.sv
src/qrs_div.sv
src/qrs_back.sv
src/quadratic_root_solver.sv
tb/quadratic_root_solver_test.sv
